@@ rtl/wrms_pkg.sv @@
package wrms_pkg;

   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 12;

   localparam int SAMPLE_W = 12;
   localparam int RMS_W    = 20;
   localparam int FRAC_W   = 8;

   localparam int ACC_W   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int COUNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = ACC_W + $clog2(MAX_SAMPLES);
   localparam int SQ_W    = 2 * ACC_W + $clog2(MAX_SAMPLES);
   localparam int SQR_W   = 2 * ACC_W;

   localparam int PROD_A_W  = COUNT_W + SQ_W;
   localparam int PROD_B_W  = 2 * SUM_W;
   localparam int RAD_RAW_W = PROD_A_W + 2 * FRAC_W;
   localparam int RAD_W     = RAD_RAW_W + (RAD_RAW_W % 2);
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 3;
   localparam int ITER_W    = $clog2(ROOT_W);
   localparam int SAT_CMP_W = ROOT_W + RMS_W;

   localparam logic [RMS_W-1:0] RMS_MAX = {RMS_W{1'b1}};

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               empty;
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
      logic [SQ_W-1:0]    sqsum;
   } wrms_job_type;

   typedef struct packed {
      logic full;
      logic avail;
   } wrms_qstat_type;

endpackage

@@ rtl/waveform_rms_accumulator.sv @@
// channel  direction  ports
// req      in         req_valid, req_stall, req_sample, req_has_sample, req_last
// rsp      out        rsp_valid, rsp_stall, rsp_rms_q8, rsp_empty_res
//
// Samples are taken one per cycle while req_stall is low, and req_stall rises
// only while the two-entry job queue holds two closed waveforms.
// A closed waveform runs MUL, SUB, SQRT and DIV in the back end: one root bit,
// then one quotient bit per cycle. An empty one skips straight to OUT.
// Synchronous active-high reset clears the accumulators, the queue and rsp_valid.
// A stalled response holds in its output register while the front keeps accepting.
module waveform_rms_accumulator import wrms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_has_sample,
   input  logic                req_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [RMS_W-1:0]    rsp_rms_q8,
   output logic                rsp_empty_res
);

   logic           push;
   wrms_job_type   push_job;
   logic           pop;
   wrms_job_type   head_job;
   wrms_qstat_type qstat;

   assign req_stall = qstat.full;

   wrms_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_has_sample (req_has_sample),
      .req_last       (req_last),
      .push           (push),
      .push_job       (push_job)
   );

   wrms_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .qstat    (qstat)
   );

   wrms_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_job      (head_job),
      .qstat         (qstat),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_rms_q8    (rsp_rms_q8),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

@@ rtl/wrms_front.sv @@
module wrms_front import wrms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_has_sample,
   input  logic                req_last,
   output logic                push,
   output wrms_job_type        push_job
);

   logic [COUNT_W-1:0] count_ff, count_in, count_next;
   logic [SUM_W-1:0]   sum_ff, sum_in, sum_next;
   logic [SQ_W-1:0]    sqsum_ff, sqsum_in, sqsum_next;
   logic [ACC_W-1:0]   smp;
   logic [SQR_W-1:0]   smp_sq;
   logic               take;
   logic               add;

   assign smp    = req_sample[ACC_W-1:0];
   assign smp_sq = SQR_W'(smp) * SQR_W'(smp);
   assign take   = req_valid && !req_stall;
   assign add    = take && req_has_sample && (count_ff < COUNT_W'(MAX_SAMPLES));

   always_comb begin
      count_next = count_ff;
      sum_next   = sum_ff;
      sqsum_next = sqsum_ff;
      if (add) begin
         count_next = count_ff + COUNT_W'(1);
         sum_next   = sum_ff + SUM_W'(smp);
         sqsum_next = sqsum_ff + SQ_W'(smp_sq);
      end
   end

   assign push           = take && req_last;
   assign push_job.empty = (count_next == '0);
   assign push_job.count = count_next;
   assign push_job.sum   = sum_next;
   assign push_job.sqsum = sqsum_next;

   assign count_in = push ? '0 : count_next;
   assign sum_in   = push ? '0 : sum_next;
   assign sqsum_in = push ? '0 : sqsum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         sqsum_ff <= sqsum_in;
      end
   end

endmodule

@@ rtl/wrms_queue.sv @@
module wrms_queue import wrms_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  wrms_job_type   push_job,
   input  logic           pop,
   output wrms_job_type   head_job,
   output wrms_qstat_type qstat
);

   wrms_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   assign qstat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.avail = (cnt_ff != '0);
   assign head_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/wrms_back.sv @@
module wrms_back import wrms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  wrms_job_type     head_job,
   input  wrms_qstat_type   qstat,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [RMS_W-1:0] rsp_rms_q8,
   output logic             rsp_empty_res
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_SUB  = 3'd2;
   localparam logic [2:0] ST_SQRT = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [ITER_W-1:0]   iter_ff, iter_in;
   wrms_job_type        job_ff, job_in;
   logic [PROD_A_W-1:0] prod_a_ff, prod_a_in;
   logic [PROD_B_W-1:0] prod_b_ff, prod_b_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [COUNT_W-1:0]  drem_ff, drem_in;
   logic [ROOT_W-1:0]   quo_ff, quo_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RMS_W-1:0]    rsp_rms_ff, rsp_rms_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [PROD_A_W-1:0] diff;
   logic [REM_W-1:0]    rem_sh;
   logic [REM_W-1:0]    trial;
   logic [COUNT_W:0]    drem_sh;
   logic                out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = (state_ff == ST_IDLE) && qstat.avail;

   assign diff    = (PROD_A_W'(prod_b_ff) > prod_a_ff) ? '0
                                                       : prod_a_ff - PROD_A_W'(prod_b_ff);
   assign rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial   = REM_W'({root_ff, 2'b01});
   assign drem_sh = {drem_ff, root_ff[ROOT_W-1]};

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      job_in       = job_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rms_in   = rsp_rms_ff;
      rsp_empty_in = rsp_empty_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (qstat.avail) begin
               job_in   = head_job;
               state_in = head_job.empty ? ST_OUT : ST_MUL;
            end
         end
         ST_MUL: begin
            prod_a_in = PROD_A_W'(job_ff.count) * PROD_A_W'(job_ff.sqsum);
            prod_b_in = PROD_B_W'(job_ff.sum) * PROD_B_W'(job_ff.sum);
            state_in  = ST_SUB;
         end
         ST_SUB: begin
            rad_in   = RAD_W'({diff, {(2 * FRAC_W){1'b0}}});
            rem_in   = '0;
            root_in  = '0;
            iter_in  = ITER_W'(ROOT_W - 1);
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (iter_ff == '0) begin
               drem_in  = '0;
               quo_in   = '0;
               iter_in  = ITER_W'(ROOT_W - 1);
               state_in = ST_DIV;
            end else begin
               iter_in = iter_ff - ITER_W'(1);
            end
         end
         ST_DIV: begin
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
            if (drem_sh >= {1'b0, job_ff.count}) begin
               drem_in = COUNT_W'(drem_sh - {1'b0, job_ff.count});
               quo_in  = {quo_ff[ROOT_W-2:0], 1'b1};
            end else begin
               drem_in = drem_sh[COUNT_W-1:0];
               quo_in  = {quo_ff[ROOT_W-2:0], 1'b0};
            end
            if (iter_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               iter_in = iter_ff - ITER_W'(1);
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = job_ff.empty;
               if (job_ff.empty) begin
                  rsp_rms_in = '0;
               end else if (SAT_CMP_W'(quo_ff) > SAT_CMP_W'(RMS_MAX)) begin
                  rsp_rms_in = RMS_MAX;
               end else begin
                  rsp_rms_in = RMS_W'(quo_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff     <= job_in;
      iter_ff    <= iter_in;
      prod_a_ff  <= prod_a_in;
      prod_b_ff  <= prod_b_in;
      rad_ff     <= rad_in;
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      drem_ff    <= drem_in;
      quo_ff     <= quo_in;
      rsp_rms_ff   <= rsp_rms_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_rms_q8    = rsp_rms_ff;
   assign rsp_empty_res = rsp_empty_ff;

endmodule
